>>> sv/anti_replay_window_check_assert.svh
// Assertion macros used by the anti-replay window check RTL (arw_window).
`ifndef ANTI_REPLAY_WINDOW_CHECK_ASSERT_SVH
`define ANTI_REPLAY_WINDOW_CHECK_ASSERT_SVH

// Checked on every clock edge outside reset.
`define ARW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ARW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/arw_pkg.sv
// Shared types and constants for the anti-replay window check.
package arw_pkg;

  localparam int unsigned CntBits  = 32;
  localparam int unsigned SeqBits  = 32;
  localparam int unsigned MapBits  = 32;
  localparam int unsigned MapIdxW  = $clog2(MapBits);
  localparam int unsigned WinW     = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgWindowSize    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgInitialOffset = CfgIdxW'(1);

  localparam logic [WinW-1:0] WinReset = WinW'(32);
  localparam logic [WinW-1:0] WinMax   = WinW'(MapBits);

  typedef enum logic [1:0] {
    VerdictAccept  = 2'd0,
    VerdictWrapped = 2'd1,
    VerdictTooOld  = 2'd2,
    VerdictDup     = 2'd3
  } verdict_e;

  typedef struct packed {
    verdict_e verdict;
    logic     advanced;
  } result_t;

endpackage

>>> sv/arw_window.sv
// Sliding window state (highest relative number and seen bitmap) and classification.
module arw_window import arw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [CntBits-1:0] rel_i,
  input  logic [WinW-1:0]    win_size_i,
  output result_t            res_o
);

  `include "anti_replay_window_check_assert.svh"

  logic [CntBits-1:0] highest_q, highest_d;
  logic [MapBits-1:0] seen_q, seen_d;
  logic [WinW-1:0]    win;
  logic [CntBits-1:0] diff_up, diff_dn;
  logic               newer;

  assign win     = (win_size_i > WinMax) ? WinMax : win_size_i;
  assign newer   = rel_i > highest_q;
  assign diff_up = rel_i - highest_q;
  assign diff_dn = highest_q - rel_i;

  always_comb begin
    highest_d    = highest_q;
    seen_d       = seen_q;
    res_o.verdict  = VerdictAccept;
    res_o.advanced = 1'b0;
    if (rel_i == '0) begin
      res_o.verdict = VerdictWrapped;
    end else if (newer) begin
      // shift the bitmap up by the distance, or restart it past the window
      if (diff_up < CntBits'(win)) begin
        seen_d = (seen_q << diff_up[MapIdxW-1:0]) | MapBits'(1);
      end else begin
        seen_d = MapBits'(1);
      end
      highest_d      = rel_i;
      res_o.advanced = 1'b1;
    end else if (diff_dn >= CntBits'(win)) begin
      res_o.verdict = VerdictTooOld;
    end else if (seen_q[diff_dn[MapIdxW-1:0]]) begin
      res_o.verdict = VerdictDup;
    end else begin
      seen_d[diff_dn[MapIdxW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= CntBits'(1);
      seen_q    <= '0;
    end else if (step_i) begin
      highest_q <= highest_d;
      seen_q    <= seen_d;
    end
  end

  `ARW_ASSERT(a_highest_nonzero, highest_q != '0, "highest relative number is zero")
  `ARW_ASSERT(a_adv_sets_bit0, step_i && res_o.advanced |=> seen_q[0],
              "window advanced without marking the new highest")
  `ARW_ASSERT(a_adv_grows, step_i && res_o.advanced |=> highest_q > $past(highest_q),
              "window advanced without raising the highest")
  `ARW_ASSERT(a_reject_holds,
              step_i && (res_o.verdict == VerdictWrapped || res_o.verdict == VerdictTooOld ||
                         res_o.verdict == VerdictDup)
              |=> $stable(highest_q) && $stable(seen_q),
              "rejected number changed the window")

endmodule

>>> sv/anti_replay_window_check.sv
// Anti-replay sliding window check: top level with handshakes and configuration.
//
// Input channel: in_valid_i/in_ready_o carry one received seq_number_i per
// transaction. Output channel: out_valid_o/out_ready_i return verdict_o
// (accepted, wrapped, too old, duplicate) and window_advanced_o per item.
// Configuration: cfg_valid_i/cfg_ready_o write cfg_data_i to register
// cfg_index_i (0 window size, 1 initial offset); other indexes are ignored.
// cfg_ready_o is always high; write only while no item is in flight.
// Pipeline: the offset is subtracted into the input register at the
// transaction edge, then the window update and verdict are registered into
// the output register as soon as that register is free.
// Throughput: one item per cycle while out_ready_i does not stall the output,
// set by the read-modify-write of the highest number and seen bitmap.
// Reset: window size 32, offset 0, highest relative number 1, bitmap empty,
// both pipeline registers empty.
// Stall: a held result keeps out_valid_o and its payload; one more item
// waits in the input register, after which in_ready_o drops until
// out_ready_i frees the output register.
module anti_replay_window_check import arw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SeqBits-1:0]  seq_number_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          verdict_o,
  output logic                window_advanced_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [WinW-1:0]    win_size_q;
  logic [SeqBits-1:0] offset_q;
  logic               s1_valid_q;
  logic [CntBits-1:0] s1_rel_q;
  logic               out_valid_q;
  result_t            out_res_q;
  result_t            res;
  logic               out_load, step, in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WinReset;
      offset_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWindowSize:    win_size_q <= cfg_data_i[WinW-1:0];
        CfgInitialOffset: offset_q   <= cfg_data_i[SeqBits-1:0];
        default:          ;
      endcase
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // relative number, modulo the counter width
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_rel_q <= CntBits'(seq_number_i) - CntBits'(offset_q);
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  arw_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rel_i      (s1_rel_q),
    .win_size_i (win_size_q),
    .res_o      (res)
  );

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = out_res_q.verdict;
  assign window_advanced_o = out_res_q.advanced;

endmodule
